// File: rtl/adc_ladder_key_press_tracker_defines.svh
// Assertion macros used by the checker file
`ifndef ADC_LADDER_KEY_PRESS_TRACKER_DEFINES_SVH
`define ADC_LADDER_KEY_PRESS_TRACKER_DEFINES_SVH

// Property checked on every clock edge outside reset
`define ALKPT_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every clock edge, reset included
`define ALKPT_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/alkpt_pkg.sv
package alkpt_pkg;

   // Field widths
   localparam int MV_W   = 12;
   localparam int TIME_W = 32;
   localparam int MS_W   = 16;

   // Default depth of the queue between front and back
   localparam int ALKPT_QUEUE_DEPTH = 4;

   // Register indexes on the csr port
   localparam logic [2:0] CSR_UP_MIN     = 3'd0;
   localparam logic [2:0] CSR_UP_MAX     = 3'd1;
   localparam logic [2:0] CSR_DOWN_MIN   = 3'd2;
   localparam logic [2:0] CSR_DOWN_MAX   = 3'd3;
   localparam logic [2:0] CSR_OK_MIN     = 3'd4;
   localparam logic [2:0] CSR_OK_MAX     = 3'd5;
   localparam logic [2:0] CSR_DEBOUNCE   = 3'd6;
   localparam logic [2:0] CSR_LONG_PRESS = 3'd7;

   typedef enum logic [1:0] {
      KEY_IDLE = 2'd0,
      KEY_UP   = 2'd1,
      KEY_DN   = 2'd2,
      KEY_OK   = 2'd3
   } key_type;

   typedef enum logic [2:0] {
      EV_VOICE_START = 3'd0,
      EV_VOICE_END   = 3'd1,
      EV_UP_LONG     = 3'd2,
      EV_DOWN_LONG   = 3'd3,
      EV_UP_SHORT    = 3'd4,
      EV_DOWN_SHORT  = 3'd5,
      EV_OK_SHORT    = 3'd6
   } event_type;

   // Configuration registers as seen by front and back
   typedef struct packed {
      logic [MV_W-1:0] up_min_mv;
      logic [MV_W-1:0] up_max_mv;
      logic [MV_W-1:0] down_min_mv;
      logic [MV_W-1:0] down_max_mv;
      logic [MV_W-1:0] ok_min_mv;
      logic [MV_W-1:0] ok_max_mv;
      logic [MS_W-1:0] debounce_time_ms;
      logic [MS_W-1:0] long_press_time_ms;
   } cfg_type;

   // A debounced sample handed from front to back
   typedef struct packed {
      key_type           raw_key;
      logic [TIME_W-1:0] time_ms;
   } item_type;

   // Queue write or read side: valid plus item
   typedef struct packed {
      logic     valid;
      item_type item;
   } q_port_type;

   // Result of one tracker step
   typedef struct packed {
      event_type event_code;
      logic      recording_active;
      key_type   held_key;
   } result_type;

endpackage

// File: rtl/alkpt_front.sv
module alkpt_front import alkpt_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              accept,
   input  logic [MV_W-1:0]   millivolts,
   input  logic [TIME_W-1:0] time_ms,
   output q_port_type        push
);

   key_type           last_raw_ff, last_raw_in;
   logic [TIME_W-1:0] stable_since_ff, stable_since_in;
   key_type           raw_key;
   logic [TIME_W-1:0] held_for;

   // Window sort, first match wins: up, down, ok
   always_comb begin
      if (millivolts >= cfg.up_min_mv && millivolts < cfg.up_max_mv) begin
         raw_key = KEY_UP;
      end else if (millivolts >= cfg.down_min_mv && millivolts < cfg.down_max_mv) begin
         raw_key = KEY_DN;
      end else if (millivolts >= cfg.ok_min_mv && millivolts < cfg.ok_max_mv) begin
         raw_key = KEY_OK;
      end else begin
         raw_key = KEY_IDLE;
      end
   end

   // Debounce timer restarts on a change of key
   always_comb begin
      last_raw_in     = last_raw_ff;
      stable_since_in = stable_since_ff;
      if (accept && raw_key != last_raw_ff) begin
         last_raw_in     = raw_key;
         stable_since_in = time_ms;
      end
      held_for = time_ms - stable_since_in;
   end

   // Stable samples go on to the tracker
   assign push.valid        = accept &&
                              (held_for >= {{(TIME_W-MS_W){1'b0}}, cfg.debounce_time_ms});
   assign push.item.raw_key = raw_key;
   assign push.item.time_ms = time_ms;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_raw_ff     <= KEY_IDLE;
         stable_since_ff <= '0;
      end else begin
         last_raw_ff     <= last_raw_in;
         stable_since_ff <= stable_since_in;
      end
   end

endmodule

// File: rtl/alkpt_queue.sv
module alkpt_queue import alkpt_pkg::*; #(
   parameter int DEPTH = ALKPT_QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  q_port_type push,
   output logic       full,
   output q_port_type head,
   input  logic       pop
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   item_type        mem_ff [DEPTH];
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_push;
   logic            do_pop;

   assign full      = (count_ff == CW'(DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.item  = mem_ff[rd_ptr_ff];

   assign do_push = push.valid && !full;
   assign do_pop  = pop && head.valid;

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.item;
      end
   end

endmodule

// File: rtl/alkpt_back.sv
module alkpt_back import alkpt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  q_port_type head,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output result_type rsp_result
);

   key_type           tracked_ff, tracked_in;
   logic [TIME_W-1:0] press_start_ff, press_start_in;
   logic              long_fired_ff, long_fired_in;
   logic              recording_ff, recording_in;
   logic              rsp_valid_ff, rsp_valid_in;
   result_type        rsp_result_ff, rsp_result_in;
   logic              emit;
   event_type         code;
   logic [TIME_W-1:0] pressed_for;
   key_type           raw;

   assign raw         = head.item.raw_key;
   assign pressed_for = head.item.time_ms - press_start_ff;

   // Take the next item whenever the output register is free or draining
   assign pop = head.valid && (!rsp_valid_ff || rsp_ready);

   // Press tracker step
   always_comb begin
      tracked_in     = tracked_ff;
      press_start_in = press_start_ff;
      long_fired_in  = long_fired_ff;
      recording_in   = recording_ff;
      emit           = 1'b0;
      code           = EV_OK_SHORT;
      if (raw != KEY_IDLE && tracked_ff == KEY_IDLE) begin
         // New press
         tracked_in     = raw;
         press_start_in = head.item.time_ms;
         long_fired_in  = 1'b0;
      end else if (raw != KEY_IDLE && tracked_ff == raw) begin
         // Held: one long event once the hold time is reached
         if (!long_fired_ff &&
             pressed_for >= {{(TIME_W-MS_W){1'b0}}, cfg.long_press_time_ms}) begin
            long_fired_in = 1'b1;
            emit          = 1'b1;
            if (raw == KEY_OK) begin
               recording_in = 1'b1;
               code         = EV_VOICE_START;
            end else if (raw == KEY_UP) begin
               code = EV_UP_LONG;
            end else begin
               code = EV_DOWN_LONG;
            end
         end
      end else if (raw == KEY_IDLE && tracked_ff != KEY_IDLE) begin
         // Release
         tracked_in = KEY_IDLE;
         if (tracked_ff == KEY_OK && recording_ff) begin
            recording_in = 1'b0;
            emit         = 1'b1;
            code         = EV_VOICE_END;
         end else if (!long_fired_ff) begin
            emit = 1'b1;
            unique case (tracked_ff)
               KEY_UP:  code = EV_UP_SHORT;
               KEY_DN:  code = EV_DOWN_SHORT;
               default: code = EV_OK_SHORT;
            endcase
         end
      end
   end

   // Output register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_result_in = rsp_result_ff;
      if (pop) begin
         rsp_valid_in                   = emit;
         rsp_result_in.event_code       = code;
         rsp_result_in.recording_active = recording_in;
         rsp_result_in.held_key         = tracked_in;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tracked_ff     <= KEY_IDLE;
         press_start_ff <= '0;
         long_fired_ff  <= 1'b0;
         recording_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            tracked_ff     <= tracked_in;
            press_start_ff <= press_start_in;
            long_fired_ff  <= long_fired_in;
            recording_ff   <= recording_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_result_ff <= rsp_result_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_result_ff;

endmodule

// File: rtl/adc_ladder_key_press_tracker.sv
// Channel  | Ports         | Payload
// ---------+---------------+-------------------------------------------------
// request  | req_t*        | tdata: millivolts[11:0], time_ms[43:12], zeros
// response | rsp_t*        | tdata: event_code[2:0], recording_active[3],
//          |               |        held_key[5:4], zeros
// csr      | csr_*         | write enable, 3-bit index, 16-bit data
//
// One sample per cycle sustained while responses are taken. The front
// classifies and debounces a sample in the cycle it is accepted; the back runs
// the press tracker on one queued sample per cycle and registers its result, so
// a sample passes the queue storage, then the output register. Reset is
// synchronous and clears all state but the result data register, and empties
// the queue. A stalled response fills the queue; req_tready drops only when it is full.
module adc_ladder_key_press_tracker import alkpt_pkg::*; #(
   parameter int QUEUE_DEPTH = ALKPT_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // millivolts, time_ms
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // event_code, recording_active, held_key
   input  logic        csr_wen,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   cfg_type    cfg_ff;
   q_port_type push;
   q_port_type head;
   logic       full;
   logic       pop;
   logic       req_accept;
   result_type result;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.up_min_mv          <= 12'd0;
         cfg_ff.up_max_mv          <= 12'd150;
         cfg_ff.down_min_mv        <= 12'd150;
         cfg_ff.down_max_mv        <= 12'd447;
         cfg_ff.ok_min_mv          <= 12'd447;
         cfg_ff.ok_max_mv          <= 12'd1900;
         cfg_ff.debounce_time_ms   <= 16'd50;
         cfg_ff.long_press_time_ms <= 16'd1000;
      end else if (csr_wen) begin
         unique case (csr_index)
            CSR_UP_MIN:     cfg_ff.up_min_mv          <= csr_wdata[MV_W-1:0];
            CSR_UP_MAX:     cfg_ff.up_max_mv          <= csr_wdata[MV_W-1:0];
            CSR_DOWN_MIN:   cfg_ff.down_min_mv        <= csr_wdata[MV_W-1:0];
            CSR_DOWN_MAX:   cfg_ff.down_max_mv        <= csr_wdata[MV_W-1:0];
            CSR_OK_MIN:     cfg_ff.ok_min_mv          <= csr_wdata[MV_W-1:0];
            CSR_OK_MAX:     cfg_ff.ok_max_mv          <= csr_wdata[MV_W-1:0];
            CSR_DEBOUNCE:   cfg_ff.debounce_time_ms   <= csr_wdata;
            CSR_LONG_PRESS: cfg_ff.long_press_time_ms <= csr_wdata;
         endcase
      end
   end

   assign req_tready = !full;
   assign req_accept = req_tvalid && req_tready;

   alkpt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .accept     (req_accept),
      .millivolts (req_tdata[MV_W-1:0]),
      .time_ms    (req_tdata[MV_W+TIME_W-1:MV_W]),
      .push       (push)
   );

   alkpt_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (full),
      .head  (head),
      .pop   (pop)
   );

   alkpt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head       (head),
      .pop        (pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_result (result)
   );

   assign rsp_tdata = {2'b00, result.held_key, result.recording_active, result.event_code};

endmodule

// File: rtl/alkpt_checker.sv
`include "adc_ladder_key_press_tracker_defines.svh"

module alkpt_checker import alkpt_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata
);

   logic [2:0] ev;
   logic       rec;
   logic [1:0] held;

   assign ev   = rsp_tdata[2:0];
   assign rec  = rsp_tdata[3];
   assign held = rsp_tdata[5:4];

   // Stalled response transaction holds
   `ALKPT_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "response changed while stalled")

   // No response right after reset
   `ALKPT_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_tvalid, "response valid after reset")

   // Voice start means ok is held and recording is on
   `ALKPT_ASSERT(a_voice_start, clock, reset, rsp_tvalid && ev == EV_VOICE_START |-> rec && held == KEY_OK, "voice start without ok held and recording")

   // Voice end and short events follow a release
   `ALKPT_ASSERT(a_release, clock, reset, rsp_tvalid && (ev == EV_VOICE_END || ev == EV_UP_SHORT || ev == EV_DOWN_SHORT || ev == EV_OK_SHORT) |-> held == KEY_IDLE, "release event with key still held")

   // Long events name the held key
   `ALKPT_ASSERT(a_long_key, clock, reset, rsp_tvalid && (ev == EV_UP_LONG || ev == EV_DOWN_LONG) |-> (ev == EV_UP_LONG && held == KEY_UP) || (ev == EV_DOWN_LONG && held == KEY_DN), "long event does not match held key")

endmodule

bind adc_ladder_key_press_tracker alkpt_checker u_alkpt_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
